// ===== src/sdtu_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtu_pkg: shared types and constants
// Operation codes, decoded command record and result record for the
// single data transfer unit.
// ----------------------------------------------------------------------------
package sdtu_pkg;

    typedef enum logic [2:0] {
        OP_EXEC  = 3'd0,
        OP_MEMWR = 3'd1,
        OP_MEMRD = 3'd2,
        OP_REGRD = 3'd3,
        OP_REGWR = 3'd4
    } op_t;

    localparam logic [3:0] PC_REG = 4'd15;

    // Shift type codes of the offset shifter.
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic        mem_en;     // memory access happens
        logic        mem_wr;     // memory access is a store
        logic        rf_rd;      // result is a register read
        logic        load_wb;    // load result goes to rd
        logic        base_wb;    // post-index writeback to rn
        logic        reg_wr;     // direct register write
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [3:0]  ridx;
        logic        fault;
        logic        was_load;
        logic [31:0] addr;
        logic [31:0] wdata;      // store, register write or register read data
        logic [31:0] adjusted;   // writeback value
    } cmd_t;

    typedef struct packed {
        logic        fault;
        logic [31:0] access_address;
        logic [31:0] read_data;
        logic        was_load;
    } res_t;

    function automatic logic [31:0] barrel(input logic [31:0] v, input logic [1:0] ty,
                                          input logic [7:0] amt);
        logic [31:0] r;
        logic [4:0]  a5;
        begin
            a5 = amt[4:0];
            r = v;
            if (amt != 8'd0)
            begin
                case (ty)
                    SH_LSL: r = (amt >= 8'd32) ? 32'd0 : (v << a5);
                    SH_LSR: r = (amt >= 8'd32) ? 32'd0 : (v >> a5);
                    SH_ASR: r = (amt >= 8'd32) ? {32{v[31]}} : 32'($signed(v) >>> a5);
                    default: r = (a5 == 5'd0) ? v : ((v >> a5) | (v << (6'd32 - {1'b0, a5})));
                endcase
            end
            return r;
        end
    endfunction

endpackage

// ===== src/single_data_transfer_unit_core.sv =====
// ----------------------------------------------------------------------------
// single_data_transfer_unit_core: load/store word unit
// A result beat is registered in the back part and then written into the
// output queue before it can be taken. Throughput: one beat per cycle while
// the queue has room, except that any beat right behind an in-bounds load
// waits for the loaded word. Reset: rst_n clears the register file, control
// and the queue at once; then every row of the byte memory is cleared, one
// row per cycle, with s_tready low. The output queue holds two results.
// ----------------------------------------------------------------------------
module single_data_transfer_unit_core
    import sdtu_pkg::*;
#(
    parameter int MEMORY_BYTES = 65536
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, lowest bit up: op[2:0], instruction[34:3], pc_value[66:35],
    // byte_address[82:67], data_word[114:83], reg_index[118:115], zero fill
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata, lowest bit up: fault[0], access_address[32:1], read_data[64:33],
    // was_load[65], zero fill
    output logic [71:0]  m_tdata
);

    cmd_t        cmd;
    res_t        res;
    logic        res_valid, fire, ld_hazard_reg, clearing, pop;
    logic [31:0] load_data;

    // Output queue of two results: the in-flight beat always has a slot.
    res_t        q_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    // A new beat is taken when the queue, after this edge, keeps a slot for
    // it beside the result already in flight. A register is written from a
    // load in the cycle after it is accepted; any beat right behind an
    // in-bounds load waits. Nothing is taken while memory is being cleared.
    assign s_tready = (({1'b0, cnt_reg} + 3'(res_valid)) <= (3'd1 + 3'(pop)))
                      && !ld_hazard_reg && !clearing;
    assign fire = s_tvalid && s_tready;

    sdtu_front #(.MEMORY_BYTES(MEMORY_BYTES)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (s_tdata[2:0]),
        .instruction  (s_tdata[34:3]),
        .pc_value     (s_tdata[66:35]),
        .byte_address (s_tdata[82:67]),
        .data_word    (s_tdata[114:83]),
        .reg_index    (s_tdata[118:115]),
        .fire         (fire),
        .load_data    (load_data),
        .cmd          (cmd)
    );

    sdtu_back #(.MEMORY_BYTES(MEMORY_BYTES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .cmd       (cmd),
        .clearing  (clearing),
        .res_valid (res_valid),
        .res       (res),
        .load_data (load_data)
    );

    assign pop = m_tvalid && m_tready;
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata = {6'd0, q_reg[rp_reg].was_load, q_reg[rp_reg].read_data,
                      q_reg[rp_reg].access_address, q_reg[rp_reg].fault};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
            ld_hazard_reg <= 1'b0;
        end
        else
        begin
            ld_hazard_reg <= fire && cmd.load_wb;
            if (res_valid)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(res_valid) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            q_reg[wp_reg] <= res;
    end

endmodule

// ===== src/sdtu_ram.sv =====
// ----------------------------------------------------------------------------
// sdtu_ram: generic single port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sdtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem_reg[addr] <= wdata;
            else
                rdata <= mem_reg[addr];
        end
    end

endmodule

// ===== src/sdtu_front.sv =====
// ----------------------------------------------------------------------------
// sdtu_front: decode and address stage
// Reads the register file, forms the offset and effective address, checks
// bounds and produces a classified command. Holds the register file, so
// register updates take effect for the very next beat.
// ----------------------------------------------------------------------------
module sdtu_front
    import sdtu_pkg::*;
#(
    parameter int MEMORY_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  op,
    input  logic [31:0] instruction,
    input  logic [31:0] pc_value,
    input  logic [15:0] byte_address,
    input  logic [31:0] data_word,
    input  logic [3:0]  reg_index,
    input  logic        fire,
    input  logic [31:0] load_data,
    output cmd_t        cmd
);

    localparam logic [32:0] LIMIT = 33'(MEMORY_BYTES);

    logic [31:0] rf_reg [16];

    logic [3:0]  rn, rd, rm, rs;
    logic        pre, up, load;
    logic [31:0] base, offset, adjusted, addr;
    logic        fits;

    always_comb
    begin
        rn   = instruction[19:16];
        rd   = instruction[15:12];
        rm   = instruction[3:0];
        rs   = instruction[11:8];
        pre  = instruction[24];
        up   = instruction[23];
        load = instruction[20];
        base = (rn == PC_REG) ? pc_value : rf_reg[rn];
        if (instruction[25])
            offset = barrel(rf_reg[rm], instruction[6:5],
                            instruction[4] ? rf_reg[rs][7:0] : {3'd0, instruction[11:7]});
        else
            offset = {20'd0, instruction[11:0]};
        adjusted = up ? base + offset : base - offset;
        addr = OP_EXEC == op_t'(op) ? (pre ? adjusted : base) : {16'd0, byte_address};
        fits = ({1'b0, addr} + 33'd4) <= LIMIT;

        cmd = '0;
        cmd.rd = rd;
        cmd.rn = rn;
        cmd.ridx = reg_index;
        cmd.adjusted = adjusted;
        case (op_t'(op))
            OP_EXEC:
            begin
                cmd.addr = addr;
                cmd.was_load = load;
                cmd.fault = !fits;
                cmd.mem_en = fits;
                cmd.mem_wr = !load;
                cmd.load_wb = fits && load;
                cmd.base_wb = fits && !pre;
                cmd.wdata = rf_reg[rd];
            end
            OP_MEMWR, OP_MEMRD:
            begin
                cmd.addr = addr;
                cmd.fault = !fits;
                cmd.mem_en = fits;
                cmd.mem_wr = op_t'(op) == OP_MEMWR;
                cmd.wdata = data_word;
            end
            OP_REGRD:
            begin
                cmd.rf_rd = 1'b1;
                cmd.wdata = rf_reg[reg_index];
            end
            OP_REGWR:
            begin
                cmd.reg_wr = 1'b1;
                cmd.wdata = data_word;
            end
            default: ;
        endcase
    end

    // Loads need the memory word, which the back part returns in the cycle
    // after the beat is accepted. The register file stays here, so the loaded
    // word is written then while the top level holds off the next beat.
    logic        ld_pend_reg;
    logic [3:0]  ld_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                rf_reg[i] <= 32'd0;
            ld_pend_reg <= 1'b0;
            ld_rd_reg <= 4'd0;
        end
        else
        begin
            if (ld_pend_reg)
                rf_reg[ld_rd_reg] <= load_data;
            if (fire)
            begin
                if (cmd.reg_wr)
                    rf_reg[cmd.ridx] <= cmd.wdata;
                if (cmd.base_wb)
                    rf_reg[cmd.rn] <= cmd.adjusted;
            end
            ld_pend_reg <= fire && cmd.load_wb && !(cmd.base_wb && cmd.rn == cmd.rd);
            ld_rd_reg <= cmd.rd;
        end
    end

endmodule

// ===== src/sdtu_back.sv =====
// ----------------------------------------------------------------------------
// sdtu_back: memory stage
// Four byte banks make an unaligned word one access per bank; read data
// comes in the cycle after the access and is merged into the result.
// After reset the banks are cleared one row per cycle.
// ----------------------------------------------------------------------------
module sdtu_back
    import sdtu_pkg::*;
#(
    parameter int MEMORY_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  cmd_t        cmd,
    output logic        clearing,
    output logic        res_valid,
    output res_t        res,
    output logic [31:0] load_data
);

    localparam int BANK_DEPTH = (MEMORY_BYTES + 3) / 4;
    localparam int AW = $clog2(BANK_DEPTH);
    localparam logic [AW-1:0] LAST_ROW = AW'(BANK_DEPTH - 1);

    logic [7:0]    bank_rd [4];
    logic [1:0]    sel_reg;
    logic          mem_rd_reg;
    res_t          meta_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_row_reg;

    assign clearing = clr_busy_reg;

    genvar b;
    generate
        for (b = 0; b < 4; b++)
        begin : g_bank
            // Bank b holds the word byte whose address has low bits b.
            logic [1:0]    j;
            logic [31:0]   a;
            logic [AW-1:0] row;
            logic [7:0]    wr_byte;
            assign j = 2'(2'(b) - cmd.addr[1:0]);
            assign a = cmd.addr + {30'd0, j};
            assign row = AW'(a >> 2);
            assign wr_byte = cmd.wdata[8*j +: 8];
            sdtu_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram (
                .clk   (clk),
                .en    (clr_busy_reg || (fire && cmd.mem_en)),
                .we    (clr_busy_reg || cmd.mem_wr),
                .addr  (clr_busy_reg ? clr_row_reg : row),
                .wdata (clr_busy_reg ? 8'd0 : wr_byte),
                .rdata (bank_rd[b])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid <= 1'b0;
            mem_rd_reg <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_row_reg <= '0;
        end
        else
        begin
            res_valid <= fire;
            mem_rd_reg <= fire && cmd.mem_en && !cmd.mem_wr;
            if (clr_busy_reg)
            begin
                clr_row_reg <= clr_row_reg + AW'(1);
                if (clr_row_reg == LAST_ROW)
                    clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sel_reg <= cmd.addr[1:0];
            meta_reg.fault <= cmd.fault;
            meta_reg.access_address <= cmd.addr;
            meta_reg.was_load <= cmd.was_load;
            meta_reg.read_data <= cmd.rf_rd ? cmd.wdata : 32'd0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            load_data[8*i +: 8] = bank_rd[2'(sel_reg + 2'(i))];
        res = meta_reg;
        if (mem_rd_reg)
            res.read_data = load_data;
    end

endmodule

// ===== src/single_data_transfer_unit_core_checker.sv =====
// ----------------------------------------------------------------------------
// single_data_transfer_unit_core_checker: port-level assertions
// Watches the stream ports of the unit over time.
// ----------------------------------------------------------------------------
module single_data_transfer_unit_core_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [119:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[71:66] == 6'd0) else $error("fill bits set");

    a_fault_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[64:33] == 32'd0) else $error("fault data");

    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_tready, m_tvalid})) else $error("handshake unknown");

endmodule

bind single_data_transfer_unit_core single_data_transfer_unit_core_checker u_chk (.*);
